>>> rtl/ssfs_pkg.sv
package ssfs_pkg;

  // One input beat: a bit-interval tick or a frame load.
  typedef struct packed {
    logic       func;
    logic [7:0] seg_digit0;
    logic [7:0] seg_digit1;
    logic [7:0] seg_digit2;
    logic [7:0] seg_digit3;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic busy_res;
    logic frame_done;
    logic load_rejected;
  } out_item_t;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  localparam logic [7:0] WRITE_CMD = 8'h40;
  localparam logic [7:0] ADDR_CMD  = 8'hC0;
  localparam logic [7:0] DISP_CMD  = 8'h88;

  localparam logic [2:0] BRIGHT_RESET = 3'd4;

endpackage

>>> rtl/seven_segment_serial_frame_sender.sv
// Two-wire serial frame sender for a four-digit seven-segment display.
// A load beat latches four segment bytes and starts a 210-interval frame;
// each following tick beat returns the clock and data pin levels for one bit
// interval: start, data command 0x40, stop, start, address 0xC0, four
// segment bytes LSB first, stop, start, display command 0x88 | brightness,
// stop. Each byte is eight bits of three intervals plus three acknowledge
// intervals with data released; the acknowledge is never sampled. A load
// while a frame is in progress is dropped and flagged. When idle both pins
// read high. Throughput is one beat per clock while the skid entry is free:
// the frame position is kept as a set of small counters (transaction,
// section, byte, bit, sub-interval), so the pin levels come from a short mux
// in the same cycle the beat is taken, and the result lands in an output
// register backed by one skid entry. brightness may be written only while no
// frame is pending.
module seven_segment_serial_frame_sender (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ssfs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ssfs_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_wdata_i
);

  // section codes within one transaction
  localparam logic [1:0] SEC_START = 2'd0;
  localparam logic [1:0] SEC_DATA  = 2'd1;
  localparam logic [1:0] SEC_STOP  = 2'd2;

  localparam logic [3:0] BIT_ACK = 4'd8;  // bit slot 8 is the acknowledge

  logic [2:0] bright_q;
  logic [7:0] seg_q [4];

  // frame position
  logic       sending_q, sending_d;
  logic [1:0] grp_q, grp_d;     // transaction 0..2
  logic [1:0] sec_q, sec_d;
  logic [1:0] pos_q, pos_d;     // interval inside start/stop
  logic [2:0] byte_q, byte_d;   // byte inside transaction
  logic [3:0] bitn_q, bitn_d;   // bit slot, BIT_ACK for acknowledge
  logic [1:0] sub_q, sub_d;     // interval inside a bit slot
  logic       held_dio_q, held_dio_d;

  // output register plus skid entry
  logic                out_v_q, skid_v_q;
  ssfs_pkg::out_item_t out_q, skid_q;
  ssfs_pkg::out_item_t res;

  logic       accept, pop, is_load, is_tick;
  logic [7:0] cur_byte;
  logic [2:0] byte_m1;
  logic       last_byte;
  logic       cur_bit;
  logic       tick_clk, tick_dio;
  logic       frame_end;

  assign in_ready_o  = !skid_v_q;
  assign accept      = in_valid_i && in_ready_o;
  assign pop         = out_v_q && out_ready_i;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  assign is_load = accept && (in_data_i.func == ssfs_pkg::FUNC_LOAD);
  assign is_tick = accept && (in_data_i.func == ssfs_pkg::FUNC_TICK) && sending_q;

  // byte being shifted out
  assign byte_m1 = byte_q - 3'd1;
  always_comb begin
    case (grp_q)
      2'd0:    cur_byte = ssfs_pkg::WRITE_CMD;
      2'd1:    cur_byte = (byte_q == 3'd0) ? ssfs_pkg::ADDR_CMD : seg_q[byte_m1[1:0]];
      default: cur_byte = ssfs_pkg::DISP_CMD | {5'd0, bright_q};
    endcase
  end
  assign cur_bit   = cur_byte[bitn_q[2:0]];
  assign last_byte = (grp_q == 2'd1) ? (byte_q == 3'd4) : (byte_q == 3'd0);
  assign frame_end = (grp_q == 2'd2) && (sec_q == SEC_STOP) && (pos_q == 2'd3);

  // pin levels for the current interval
  always_comb begin
    tick_clk = 1'b1;
    tick_dio = 1'b1;
    case (sec_q)
      SEC_START: begin
        tick_clk = (pos_q != 2'd2);
        tick_dio = (pos_q == 2'd0);
      end
      SEC_DATA: begin
        if (bitn_q == BIT_ACK) begin
          tick_clk = (sub_q == 2'd1);
          tick_dio = 1'b1;
        end else begin
          tick_clk = (sub_q == 2'd2);
          tick_dio = (sub_q == 2'd0) ? held_dio_q : cur_bit;
        end
      end
      SEC_STOP: begin
        case (pos_q)
          2'd0:    begin tick_clk = 1'b0; tick_dio = held_dio_q; end
          2'd1:    begin tick_clk = 1'b0; tick_dio = 1'b0; end
          2'd2:    begin tick_clk = 1'b1; tick_dio = 1'b0; end
          default: begin tick_clk = 1'b1; tick_dio = 1'b1; end
        endcase
      end
      default: begin
        tick_clk = 1'b1;
        tick_dio = 1'b1;
      end
    endcase
  end

  // position advance
  always_comb begin
    sending_d  = sending_q;
    grp_d      = grp_q;
    sec_d      = sec_q;
    pos_d      = pos_q;
    byte_d     = byte_q;
    bitn_d     = bitn_q;
    sub_d      = sub_q;
    held_dio_d = held_dio_q;
    if (is_load && !sending_q) begin
      sending_d = 1'b1;
    end else if (is_tick) begin
      held_dio_d = tick_dio;
      case (sec_q)
        SEC_START: begin
          if (pos_q == 2'd2) begin
            sec_d  = SEC_DATA;
            pos_d  = 2'd0;
            byte_d = 3'd0;
            bitn_d = 4'd0;
            sub_d  = 2'd0;
          end else begin
            pos_d = pos_q + 2'd1;
          end
        end
        SEC_DATA: begin
          if (sub_q != 2'd2) begin
            sub_d = sub_q + 2'd1;
          end else begin
            sub_d = 2'd0;
            if (bitn_q != BIT_ACK) begin
              bitn_d = bitn_q + 4'd1;
            end else begin
              bitn_d = 4'd0;
              if (last_byte) begin
                sec_d  = SEC_STOP;
                pos_d  = 2'd0;
                byte_d = 3'd0;
              end else begin
                byte_d = byte_q + 3'd1;
              end
            end
          end
        end
        default: begin
          if (pos_q != 2'd3) begin
            pos_d = pos_q + 2'd1;
          end else begin
            sec_d = SEC_START;
            pos_d = 2'd0;
            if (frame_end) begin
              grp_d     = 2'd0;
              sending_d = 1'b0;
            end else begin
              grp_d = grp_q + 2'd1;
            end
          end
        end
      endcase
    end
  end

  // result of the beat being accepted
  always_comb begin
    res.clk_level     = is_tick ? tick_clk : 1'b1;
    res.dio_level     = is_tick ? tick_dio : 1'b1;
    res.busy_res      = sending_d;
    res.frame_done    = is_tick && frame_end;
    res.load_rejected = is_load && sending_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q   <= ssfs_pkg::BRIGHT_RESET;
      sending_q  <= 1'b0;
      grp_q      <= 2'd0;
      sec_q      <= SEC_START;
      pos_q      <= 2'd0;
      byte_q     <= 3'd0;
      bitn_q     <= 4'd0;
      sub_q      <= 2'd0;
      held_dio_q <= 1'b1;
      out_v_q    <= 1'b0;
      skid_v_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bright_q <= cfg_wdata_i;
      end
      sending_q  <= sending_d;
      grp_q      <= grp_d;
      sec_q      <= sec_d;
      pos_q      <= pos_d;
      byte_q     <= byte_d;
      bitn_q     <= bitn_d;
      sub_q      <= sub_d;
      held_dio_q <= held_dio_d;
      if (skid_v_q) begin
        if (pop) begin
          skid_v_q <= 1'b0;
        end
      end else if (accept) begin
        if (out_v_q && !out_ready_i) begin
          skid_v_q <= 1'b1;
        end else begin
          out_v_q <= 1'b1;
        end
      end else if (pop) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (is_load && !sending_q) begin
      seg_q[0] <= in_data_i.seg_digit0;
      seg_q[1] <= in_data_i.seg_digit1;
      seg_q[2] <= in_data_i.seg_digit2;
      seg_q[3] <= in_data_i.seg_digit3;
    end
    if (skid_v_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (out_v_q && !out_ready_i) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  // skid entry only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry valid with empty output register");

  // idle sender always sits at the frame start position
  a_idle_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sending_q |-> (grp_q == 2'd0 && sec_q == SEC_START && pos_q == 2'd0 &&
                    byte_q == 3'd0 && bitn_q == 4'd0 && sub_q == 2'd0))
    else $error("idle sender not at frame start");

  // a frame only ends on an accepted tick at the last interval
  a_end_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(sending_q) |-> $past(is_tick && frame_end))
    else $error("frame ended outside the last interval");

  // rejected load beats always report busy
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.load_rejected) |-> (out_q.busy_res && !out_q.frame_done))
    else $error("rejected load without busy");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

  // Frame layout, in bit intervals.
  localparam int unsigned FRAME_LEN  = 210;
  localparam int unsigned BYTE_LEN   = 27;
  localparam int unsigned START_LEN  = 3;
  localparam int unsigned BIT_SPAN   = 24;   // eight bits, three intervals each
  localparam int unsigned DIGITS_AT  = 34;   // first interval of the address transfer
  localparam int unsigned DISPLAY_AT = 176;  // first interval of the display transfer

  localparam logic [2:0] BRIGHT_MIN = 3'd0;
  localparam logic [2:0] BRIGHT_MAX = 3'd7;

  localparam int N_PHASES    = 6;
  localparam int PHASE_BEATS = 120;
  localparam int DRAIN_LIMIT = 2000;

  // The three transfers of a frame.
  typedef enum logic [1:0] {
    XFER_DATA_CMD,
    XFER_DIGITS,
    XFER_DISPLAY
  } xfer_e;

  // Results that are obvious without the predictor.
  localparam ssfs_pkg::out_item_t IDLE_PINS   = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
  localparam ssfs_pkg::out_item_t LOADED_PINS = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
  localparam ssfs_pkg::out_item_t BUSY_REJECT = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
  localparam ssfs_pkg::out_item_t NO_PIN      = '0;

  // One row of the directed part: the beat, and a hand-typed result if pinned.
  typedef struct packed {
    ssfs_pkg::in_item_t  beat;
    logic                pinned;
    ssfs_pkg::out_item_t want;
  } plan_row_t;

  // Idle ticks, a load of all-ones digits, then loads rejected mid-frame with
  // the field extremes. The frame itself is then run out by the phase closer.
  localparam int N_ROWS = 15;
  localparam plan_row_t PLAN [N_ROWS] = '{
    '{'{ssfs_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, IDLE_PINS},
    '{'{ssfs_pkg::FUNC_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, IDLE_PINS},
    '{'{ssfs_pkg::FUNC_LOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, LOADED_PINS},
    '{'{ssfs_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_PIN},
    '{'{ssfs_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_PIN},
    '{'{ssfs_pkg::FUNC_TICK, 8'hFF, 8'h00, 8'hFF, 8'h00}, 1'b0, NO_PIN},
    '{'{ssfs_pkg::FUNC_LOAD, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, BUSY_REJECT},
    '{'{ssfs_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_PIN},
    '{'{ssfs_pkg::FUNC_LOAD, 8'h01, 8'h80, 8'h7F, 8'hFE}, 1'b1, BUSY_REJECT},
    '{'{ssfs_pkg::FUNC_TICK, 8'hA5, 8'h5A, 8'h3C, 8'hC3}, 1'b0, NO_PIN},
    '{'{ssfs_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_PIN},
    '{'{ssfs_pkg::FUNC_LOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, BUSY_REJECT},
    '{'{ssfs_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_PIN},
    '{'{ssfs_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_PIN},
    '{'{ssfs_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_PIN}
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  ssfs_pkg::in_item_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  ssfs_pkg::out_item_t out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [2:0]          cfg_wdata_i = '0;

  seven_segment_serial_frame_sender dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: a private copy of the sender's state, advanced once per
  // accepted input beat.
  // ---------------------------------------------------------------------------
  logic [2:0]  brightness   = ssfs_pkg::BRIGHT_RESET;
  logic [7:0]  seg_latched [4] = '{default: 8'h00};
  logic [7:0]  interval_at  = '0;
  logic        frame_busy   = 1'b0;
  logic        held_dio     = 1'b1;   // data level of the previous interval

  ssfs_pkg::out_item_t pending_pins [$];  // results still owed by the block
  int          errors       = 0;

  // Hand-typed result for the beat on the bus, when the plan gives one.
  logic                fixed_on   = 1'b0;
  ssfs_pkg::out_item_t fixed_pins = '0;

  // Random idling on both sides is allowed while this is set.
  logic        idle_on      = 1'b0;
  int          stall_left   = 0;

  // Byte n of the given transfer.
  function automatic logic [7:0] frame_octet(xfer_e x, int unsigned n);
    case (x)
      XFER_DATA_CMD: return ssfs_pkg::WRITE_CMD;
      XFER_DISPLAY:  return ssfs_pkg::DISP_CMD | {5'b0, brightness};
      default:       return (n == 0) ? ssfs_pkg::ADDR_CMD : seg_latched[(n - 1) % 4];
    endcase
  endfunction

  // Clock and data pin levels for one interval of the frame.
  function automatic void pin_levels(input int unsigned idx,
                                     output logic clk, output logic dio);
    xfer_e       x;
    int unsigned nbytes, p, k;
    logic [7:0]  octet;
    if (idx < DIGITS_AT) begin
      x = XFER_DATA_CMD; nbytes = 1; p = idx;
    end else if (idx < DISPLAY_AT) begin
      x = XFER_DIGITS; nbytes = 5; p = idx - DIGITS_AT;
    end else begin
      x = XFER_DISPLAY; nbytes = 1; p = idx - DISPLAY_AT;
    end
    // start: both high, data falls, clock falls
    if (p < START_LEN) begin
      clk = (p < 2);
      dio = (p == 0);
      return;
    end
    p -= START_LEN;
    if (p < nbytes * BYTE_LEN) begin
      k = p % BYTE_LEN;
      octet = frame_octet(x, p / BYTE_LEN);
      if (k < BIT_SPAN) begin
        // hold old data, drive new bit, raise clock; LSB first
        clk = (k % 3 == 2);
        dio = (k % 3 == 0) ? held_dio : octet[k / 3];
      end else begin
        // acknowledge slot: data released, clock pulses once
        clk = (k == BIT_SPAN + 1);
        dio = 1'b1;
      end
      return;
    end
    p -= nbytes * BYTE_LEN;
    // stop: hold, pull data low, raise clock, release data
    case (p)
      0:       begin clk = 1'b0; dio = held_dio; end
      1:       begin clk = 1'b0; dio = 1'b0;     end
      2:       begin clk = 1'b1; dio = 1'b0;     end
      default: begin clk = 1'b1; dio = 1'b1;     end
    endcase
  endfunction

  // Advances the predicted state by one beat and returns the result it causes.
  function automatic ssfs_pkg::out_item_t advance_frame(ssfs_pkg::in_item_t beat);
    ssfs_pkg::out_item_t r;
    logic                c, d;
    r = IDLE_PINS;
    if (beat.func == ssfs_pkg::FUNC_LOAD) begin
      if (frame_busy) begin
        r.load_rejected = 1'b1;
      end else begin
        seg_latched[0] = beat.seg_digit0;
        seg_latched[1] = beat.seg_digit1;
        seg_latched[2] = beat.seg_digit2;
        seg_latched[3] = beat.seg_digit3;
        interval_at    = '0;
        frame_busy     = 1'b1;
      end
    end else if (frame_busy) begin
      c = 1'b1;
      d = 1'b1;
      if (interval_at < FRAME_LEN) pin_levels(32'(interval_at), c, d);
      held_dio    = d;
      r.clk_level = c;
      r.dio_level = d;
      if (int'(interval_at) + 1 >= FRAME_LEN) begin
        r.frame_done = 1'b1;
        frame_busy   = 1'b0;
        interval_at  = '0;
      end else begin
        interval_at = interval_at + 8'd1;
      end
    end
    r.busy_res = frame_busy;
    return r;
  endfunction

  task automatic check_field(string field, logic want_v, logic got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0b, got %0b", field, want_v, got_v);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard. Both channels are sampled at the rising edge, where inputs
  // (driven on the falling edge) are stable. The input side is handled first
  // so a same-edge result would still find its expectation.
  // ---------------------------------------------------------------------------
  ssfs_pkg::out_item_t predicted, want, got;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predicted = advance_frame(in_data_i);
        pending_pins.push_back(fixed_on ? fixed_pins : predicted);
      end
      if (out_valid_o && out_ready_i) begin
        got = out_data_o;
        if (pending_pins.size() == 0) begin
          $error("result beat with no expectation pending: %b", got);
          errors++;
        end else begin
          want = pending_pins.pop_front();
          check_field("clk_level",     want.clk_level,     got.clk_level);
          check_field("dio_level",     want.dio_level,     got.dio_level);
          check_field("busy_res",      want.busy_res,      got.busy_res);
          check_field("frame_done",    want.frame_done,    got.frame_done);
          check_field("load_rejected", want.load_rejected, got.load_rejected);
        end
      end
    end
  end

  // Result side back-pressure: random stall bursts while idling is allowed.
  always @(negedge clk_i) begin
    if (!idle_on) begin
      stall_left  = 0;
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left  = $urandom_range(1, 13) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All of them are entered and left on a falling edge.
  // ---------------------------------------------------------------------------

  // Offers one beat, optionally after an idle burst, and holds it until taken.
  task automatic put_beat(ssfs_pkg::in_item_t beat, logic pin, ssfs_pkg::out_item_t pins);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    fixed_on   = pin;
    fixed_pins = pins;
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drops valid and waits until every owed result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_pins.size() != 0);
  endtask

  // Runs any open frame to its end so the block is idle before a register
  // write (the display command picks up brightness late in the frame).
  task automatic close_frame();
    drain();
    while (frame_busy)
      put_beat('{ssfs_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_PIN);
    drain();
  endtask

  task automatic set_brightness(logic [2:0] level);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= level;
    brightness  = level;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly random, with the all-zero and all-one patterns favored.
  function automatic logic [7:0] seg_pattern();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed plan at reset brightness, then random
  // phases that each start from idle with a new brightness. Random beats are
  // mostly well-formed: a load when idle, then ticks, with the odd load
  // arriving mid-frame and the odd tick while idle.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    ssfs_pkg::in_item_t beat;
    logic [2:0]         level;
    int                 waited;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idle_on = 1'b1;
    for (int r = 0; r < N_ROWS; r++)
      put_beat(PLAN[r].beat, PLAN[r].pinned, PLAN[r].want);
    close_frame();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // one phase runs without idling; the last one too
      idle_on = (ph != 2) && (ph != N_PHASES - 1);
      case (ph)
        0:       level = BRIGHT_MAX;
        1:       level = BRIGHT_MIN;
        default: level = 3'($urandom_range(0, 7));
      endcase
      set_brightness(level);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (frame_busy)
          beat.func = ($urandom_range(0, 29) == 0) ? ssfs_pkg::FUNC_LOAD : ssfs_pkg::FUNC_TICK;
        else
          beat.func = ($urandom_range(0, 9) < 8) ? ssfs_pkg::FUNC_LOAD : ssfs_pkg::FUNC_TICK;
        beat.seg_digit0 = seg_pattern();
        beat.seg_digit1 = seg_pattern();
        beat.seg_digit2 = seg_pattern();
        beat.seg_digit3 = seg_pattern();
        put_beat(beat, 1'b0, NO_PIN);
      end
      close_frame();
    end

    // Wind down: bounded wait for stragglers, then quiet clocks to
    // catch any unexpected extra result beat.
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_pins.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (8) @(negedge clk_i);
    if (pending_pins.size() != 0) begin
      $error("%0d expected result beats never arrived", pending_pins.size());
      errors++;
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
